// File: rtl/core/sbus_pkg.sv
// ----------------------------------------------------------------------------
// sbus_pkg
// Shared constants and types for the serial bus frame decoder: frame
// layout, marker bytes, flag bit positions and the frame hand-off struct.
// ----------------------------------------------------------------------------
package sbus_pkg;

   // Marker bytes of a frame.
   localparam logic [7:0] HEADER_BYTE = 8'h0F;
   localparam logic [7:0] FOOTER_BYTE = 8'h00;

   // Frame layout after the header: data bytes, one flag byte, one footer.
   localparam int DATA_BYTES       = 22;
   localparam int FRAME_DATA_WIDTH = DATA_BYTES * 8;
   localparam int IDX_WIDTH        = 5;
   localparam logic [IDX_WIDTH-1:0] FLAG_INDEX   = IDX_WIDTH'(DATA_BYTES);
   localparam logic [IDX_WIDTH-1:0] FOOTER_INDEX = IDX_WIDTH'(DATA_BYTES + 1);

   // Channel unpacking.
   localparam int NUM_CHANNELS = 16;
   localparam int CHAN_WIDTH   = 4;
   localparam int VALUE_WIDTH  = 11;
   localparam logic [CHAN_WIDTH-1:0] LAST_CHANNEL = CHAN_WIDTH'(NUM_CHANNELS - 1);

   // Bit positions inside the flag byte.
   localparam int FAILSAFE_POS = 3;
   localparam int LOST_POS     = 2;

   // Result beat width, padded to whole bytes.
   localparam int RSP_FIELDS_WIDTH = CHAN_WIDTH + VALUE_WIDTH + 2;
   localparam int RSP_WIDTH        = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;

   // Receiver state, one-hot.
   typedef enum logic [1:0] {
      ST_HUNT    = 2'b01,
      ST_COLLECT = 2'b10
   } state_type;

   // A complete, checked frame handed to the channel emitter.
   typedef struct packed {
      logic [FRAME_DATA_WIDTH-1:0] data;
      logic                        failsafe;
      logic                        frame_lost;
   } frame_type;

endpackage

// File: rtl/core/sbus_frame_decoder.sv
// Timing: a good footer beat is followed by channel 0 on the result side
// in the next cycle; channels 1 to 15 follow one per cycle while rsp_tready is high.
// Throughput: one received byte per cycle; one frame emits 16 beats through the single
// channel emitter, and a footer is held back while it is busy.
// Reset (synchronous, active high) returns to the header search and clears
// the result channel; stored frame bytes are not cleared.
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Serial bus receiver frame decoder: collects one frame from received
// bytes and emits its sixteen 11-bit channels with the frame flags.
// ----------------------------------------------------------------------------
module sbus_frame_decoder
   import sbus_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Received byte beats.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] rx_byte
   // Channel result beats.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_WIDTH-1:0] rsp_tdata,   // [3:0] channel_index, [14:4] channel_value,
                                             // [15] failsafe, [16] frame_lost, rest zero
   output logic                 rsp_tlast    // last channel of the frame
);

   logic       byte_valid;
   logic       at_footer;
   logic       frame_good;
   frame_type  frame;

   logic                        busy_ff, busy_in;
   logic [CHAN_WIDTH-1:0]       ch_ff, ch_in;
   logic [FRAME_DATA_WIDTH-1:0] emit_ff, emit_in;
   logic                        failsafe_ff, failsafe_in;
   logic                        lost_ff, lost_in;
   logic                        rsp_beat;
   logic                        emit_free;

   sbus_assembler u_assembler (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .rx_byte    (req_tdata),
      .at_footer  (at_footer),
      .frame_good (frame_good),
      .frame      (frame)
   );

   // The emitter is free when idle or when its last beat leaves now.
   assign rsp_beat   = busy_ff && rsp_tready;
   assign emit_free  = !busy_ff || (rsp_beat && (ch_ff == LAST_CHANNEL));
   assign req_tready = !at_footer || emit_free;
   assign byte_valid = req_tvalid && req_tready;

   // Channel emitter: load a good frame, then shift out 11 bits per beat.
   always_comb begin
      busy_in     = busy_ff;
      ch_in       = ch_ff;
      emit_in     = emit_ff;
      failsafe_in = failsafe_ff;
      lost_in     = lost_ff;
      if (rsp_beat) begin
         emit_in = emit_ff >> VALUE_WIDTH;
         ch_in   = ch_ff + 1'b1;
         if (ch_ff == LAST_CHANNEL) begin
            busy_in = 1'b0;
         end
      end
      if (frame_good) begin
         busy_in     = 1'b1;
         ch_in       = '0;
         emit_in     = frame.data;
         failsafe_in = frame.failsafe;
         lost_in     = frame.frame_lost;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ch_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         ch_ff   <= ch_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      emit_ff     <= emit_in;
      failsafe_ff <= failsafe_in;
      lost_ff     <= lost_in;
   end

   // Result beat.
   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = (ch_ff == LAST_CHANNEL);
   assign rsp_tdata  = {(RSP_WIDTH - RSP_FIELDS_WIDTH)'(0), lost_ff, failsafe_ff,
                        emit_ff[VALUE_WIDTH-1:0], ch_ff};

   // A new frame is loaded only into a free emitter.
   assert property (@(posedge clock) disable iff (reset)
      frame_good |-> emit_free)
      else $error("frame loaded while channels still pending");

   // Every loaded frame starts at channel 0.
   assert property (@(posedge clock) disable iff (reset)
      frame_good |=> rsp_tvalid && ch_ff == '0)
      else $error("frame did not start at channel 0");

   // After the last channel leaves with no new frame, the output goes idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_tlast && !frame_good |=> !rsp_tvalid)
      else $error("result valid after last channel");

endmodule

// File: rtl/core/sbus_assembler.sv
// ----------------------------------------------------------------------------
// sbus_assembler
// Hunts for the header byte, shifts the data bytes of a frame into a wide
// register, keeps the flag byte and checks the footer.
// ----------------------------------------------------------------------------
module sbus_assembler
   import sbus_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      byte_valid,   // a byte beat was accepted this cycle
   input  logic [7:0] rx_byte,
   output logic      at_footer,    // the next byte is the footer
   output logic      frame_good,   // footer accepted and correct this cycle
   output frame_type frame
);

   state_type                   state_ff, state_in;
   logic [IDX_WIDTH-1:0]        byte_index_ff, byte_index_in;
   logic [FRAME_DATA_WIDTH-1:0] data_ff, data_in;
   logic [7:0]                  flag_ff, flag_in;

   assign at_footer  = (state_ff == ST_COLLECT) && (byte_index_ff == FOOTER_INDEX);
   assign frame_good = byte_valid && at_footer && (rx_byte == FOOTER_BYTE);

   assign frame.data       = data_ff;
   assign frame.failsafe   = flag_ff[FAILSAFE_POS];
   assign frame.frame_lost = flag_ff[LOST_POS];

   // Header search, byte counting and storage of data and flag bytes.
   always_comb begin
      state_in      = state_ff;
      byte_index_in = byte_index_ff;
      data_in       = data_ff;
      flag_in       = flag_ff;
      if (byte_valid) begin
         unique case (state_ff)
            ST_HUNT: begin
               if (rx_byte == HEADER_BYTE) begin
                  state_in      = ST_COLLECT;
                  byte_index_in = '0;
               end
            end
            ST_COLLECT: begin
               if (byte_index_ff == FOOTER_INDEX) begin
                  // Footer: good or bad, the search starts again.
                  state_in      = ST_HUNT;
                  byte_index_in = '0;
               end else begin
                  if (byte_index_ff == FLAG_INDEX) begin
                     flag_in = rx_byte;
                  end else begin
                     // First data byte ends up in the lowest bits.
                     data_in = {rx_byte, data_ff[FRAME_DATA_WIDTH-1:8]};
                  end
                  byte_index_in = byte_index_ff + 1'b1;
               end
            end
            default: begin
               state_in      = ST_HUNT;
               byte_index_in = '0;
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_HUNT;
         byte_index_ff <= '0;
      end else begin
         state_ff      <= state_in;
         byte_index_ff <= byte_index_in;
      end
   end

   // Frame payload.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      flag_ff <= flag_in;
   end

   // The byte counter never runs past the footer.
   assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= FOOTER_INDEX)
      else $error("byte counter beyond footer");

   // Any accepted footer returns the receiver to the header search.
   assert property (@(posedge clock) disable iff (reset)
      byte_valid && at_footer |=> state_ff == ST_HUNT && byte_index_ff == '0)
      else $error("footer did not restart the header search");

   // A byte other than the header never starts a frame.
   assert property (@(posedge clock) disable iff (reset)
      byte_valid && state_ff == ST_HUNT && rx_byte != HEADER_BYTE |=> state_ff == ST_HUNT)
      else $error("frame started without a header");

endmodule

// File: verif/tb_sbus_frame_decoder.sv
// ----------------------------------------------------------------------------
// tb_sbus_frame_decoder
// Self-checking bench for the serial bus frame decoder. Received bytes are
// streamed in with random gaps. A cycle-free model of the frame receiver
// predicts the sixteen channel beats of every good frame, and each result
// beat is checked field by field against the oldest prediction. The result
// side stalls at random and once holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_sbus_frame_decoder
   import sbus_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 200;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int MAX_REPORTS  = 100;

   // One expected channel beat.
   typedef struct {
      logic [CHAN_WIDTH-1:0]  index;
      logic [VALUE_WIDTH-1:0] value;
      logic                   failsafe;
      logic                   lost;
      logic                   last;
   } chan_beat_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;    // [7:0] rx_byte
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_WIDTH-1:0] rsp_tdata;    // [3:0] channel_index, [14:4] channel_value,
                                       // [15] failsafe, [16] frame_lost, rest zero
   logic                 rsp_tlast;    // last channel of the frame

   // Receiver model state.
   logic                 rx_hunting;
   logic [IDX_WIDTH-1:0] rx_pos;
   logic [7:0]           rx_frame [DATA_BYTES+1];

   chan_beat_type chan_expect_q [$];
   int         error_count   = 0;
   int         beats_checked = 0;
   int         bytes_sent    = 0;
   int         good_frames   = 0;
   int         dropped_frames = 0;
   int         cycle_count   = 0;
   bit         steady        = 1'b0;   // no random idling on either side while set
   bit         hold_pending  = 1'b0;   // asks the result side for one long hold-off

   sbus_frame_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats still expected", $time, chan_expect_q.size());
         $display("sbus_frame_decoder verification failed");
         $finish;
      end
   end

   // Idle length: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Advance the receiver model by one byte and queue any channel beats it yields.
   function automatic void predict_byte(logic [7:0] rx);
      logic [FRAME_DATA_WIDTH-1:0] payload;
      chan_beat_type               beat;
      if (rx_hunting) begin
         if (rx == HEADER_BYTE) begin
            rx_hunting = 1'b0;
            rx_pos     = '0;
         end
         return;
      end
      if (rx_pos < FOOTER_INDEX) begin
         rx_frame[rx_pos] = rx;
         rx_pos++;
         return;
      end
      // The footer closes the frame either way.
      rx_hunting = 1'b1;
      rx_pos     = '0;
      if (rx != FOOTER_BYTE) begin
         dropped_frames++;
         return;
      end
      good_frames++;
      for (int i = 0; i < DATA_BYTES; i++) payload[8*i +: 8] = rx_frame[i];
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         beat.index    = CHAN_WIDTH'(ch);
         beat.value    = payload[ch*VALUE_WIDTH +: VALUE_WIDTH];
         beat.failsafe = rx_frame[FLAG_INDEX][FAILSAFE_POS];
         beat.lost     = rx_frame[FLAG_INDEX][LOST_POS];
         beat.last     = (ch == NUM_CHANNELS - 1);
         chan_expect_q.push_back(beat);
      end
   endfunction

   // Offer one byte and hold it until the decoder takes it. Called and
   // returning just after a rising edge; handshake seen at the falling edge.
   task automatic send_byte(input logic [7:0] rx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
      predict_byte(rx);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [FRAME_DATA_WIDTH-1:0] payload,
                             input logic [7:0] flags, input logic [7:0] footer);
      send_byte(HEADER_BYTE);
      for (int i = 0; i < DATA_BYTES; i++) send_byte(payload[8*i +: 8]);
      send_byte(flags);
      send_byte(footer);
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // Result side pacing: random stalls, plus one long hold-off on request.
   initial begin : rsp_pacing
      int wait_cycles;
      rsp_tready = 1'b0;
      forever begin
         if (hold_pending) begin
            rsp_tready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
            hold_pending = 1'b0;
         end else begin
            wait_cycles = pick_gap();
            if (wait_cycles > 0) begin
               rsp_tready <= 1'b0;
               repeat (wait_cycles) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Check each accepted result beat against the oldest prediction.
   always @(negedge clock) begin : chan_checker
      chan_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (chan_expect_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected beat, expected none, actual data 0x%h last %0b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            want = chan_expect_q.pop_front();
            check_field("channel_index", 32'(want.index),
                        32'(rsp_tdata[CHAN_WIDTH-1:0]));
            check_field("channel_value", 32'(want.value),
                        32'(rsp_tdata[CHAN_WIDTH +: VALUE_WIDTH]));
            check_field("failsafe", 32'(want.failsafe),
                        32'(rsp_tdata[CHAN_WIDTH+VALUE_WIDTH]));
            check_field("frame_lost", 32'(want.lost),
                        32'(rsp_tdata[CHAN_WIDTH+VALUE_WIDTH+1]));
            check_field("last", 32'(want.last), 32'(rsp_tlast));
            check_field("padding", 0, 32'(rsp_tdata[RSP_WIDTH-1:RSP_FIELDS_WIDTH]));
         end
      end
   end

   // Noise while hunting, full-scale and zero channels, a header byte
   // inside the data, and a frame closed by a wrong footer.
   task automatic run_directed_frames();
      logic [FRAME_DATA_WIDTH-1:0] payload;
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HEADER_BYTE - 8'd1);
      payload = '1;
      payload[5*8 +: 8] = HEADER_BYTE;
      send_frame(payload, 8'h04, FOOTER_BYTE);
      // The wrong footer looks like a header but must not start a frame.
      send_frame('0, 8'hF3, HEADER_BYTE);
      send_frame('0, 8'hFB, FOOTER_BYTE);
   endtask

   // Mostly well-formed frames with random content, with noise bytes
   // between them, some bad footers and some stretches without idling.
   task automatic run_random_traffic();
      logic [FRAME_DATA_WIDTH-1:0] payload;
      logic [7:0]                  footer;
      int                          frame_bytes;
      int                          kind;
      frame_bytes = 0;
      while (frame_bytes < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            for (int i = 0; i < DATA_BYTES; i++) payload[8*i +: 8] = 8'($urandom_range(0, 255));
            if (kind == 1) payload = '0;
            if (kind == 2) payload = '1;
            footer = FOOTER_BYTE;
            if (kind == 3) footer = 8'($urandom_range(1, 255));
            steady = (kind == 9);
            send_frame(payload, 8'($urandom_range(0, 255)), footer);
            steady = 1'b0;
            frame_bytes += DATA_BYTES + 3;
         end
      end
   endtask

   // Long result-side hold-off while frames keep coming back to back.
   task automatic run_output_stall();
      logic [FRAME_DATA_WIDTH-1:0] payload;
      hold_pending = 1'b1;
      repeat (3) begin
         for (int i = 0; i < DATA_BYTES; i++) payload[8*i +: 8] = 8'($urandom_range(0, 255));
         steady = 1'b1;
         send_frame(payload, 8'($urandom_range(0, 255)), FOOTER_BYTE);
      end
      steady = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rx_hunting = 1'b1;
      rx_pos     = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_directed_frames();
      run_random_traffic();
      run_output_stall();
      req_tvalid <= 1'b0;

      // Drain everything still expected, then let the decoder settle.
      while (chan_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes: %0d good frames, %0d frames with a bad footer.",
               bytes_sent, good_frames, dropped_frames);
      $display("Checked %0d channel beats, %0d errors.", beats_checked, error_count);
      if (error_count == 0) begin
         $display("sbus_frame_decoder verification clean");
      end else begin
         $display("sbus_frame_decoder verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/sbus_pkg.sv
rtl/core/sbus_assembler.sv
rtl/core/sbus_frame_decoder.sv
verif/tb_sbus_frame_decoder.sv
